FILE: sv/tbsf_pkg.sv
// shared types, constants and the stuffing classifier for the byte-stuffed framer
package tbsf_pkg;

  // frame delimiter, escape mark and the xor applied to an escaped byte
  localparam logic [7:0] FRAME_MARK  = 8'h5E;
  localparam logic [7:0] ESCAPE_MARK = 8'h5D;
  localparam logic [7:0] STUFF_XOR   = 8'h60;

  // number of stuffed payload bytes per frame: identifier, value low, value high
  localparam int PAYLOAD_BYTES = 3;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input word
  typedef struct packed {
    logic [7:0]  sensor_id;
    logic [15:0] sample_value;
  } item_word_t;

  // output word
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } line_word_t;

  // classified frame: payload bytes already xored where an escape is due
  typedef struct packed {
    logic [PAYLOAD_BYTES-1:0][7:0] data;
    logic [PAYLOAD_BYTES-1:0]      esc;
  } frame_t;

  // true for a byte that collides with a mark and must be escaped
  function automatic logic needs_escape(input logic [7:0] b);
    return (b == ESCAPE_MARK) || (b == FRAME_MARK);
  endfunction

  // byte as it goes out after an escape, or unchanged
  function automatic logic [7:0] stuff_byte(input logic [7:0] b);
    return needs_escape(b) ? (b ^ STUFF_XOR) : b;
  endfunction

endpackage

FILE: sv/tbsf_front.sv
// front stage: takes input words and classifies their bytes for stuffing
module tbsf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  tbsf_pkg::item_word_t item_data,
  output logic                frame_valid,
  input  logic                frame_stall,
  output tbsf_pkg::frame_t    frame_data
);

  logic              load;
  logic [2:0][7:0]   raw;
  tbsf_pkg::frame_t  classified;

  // transmit order of payload bytes
  assign raw[0] = item_data.sensor_id;
  assign raw[1] = item_data.sample_value[7:0];
  assign raw[2] = item_data.sample_value[15:8];

  // per-byte escape flag and stuffed value
  always_comb begin
    for (int i = 0; i < tbsf_pkg::PAYLOAD_BYTES; i++) begin
      classified.esc[i]  = tbsf_pkg::needs_escape(raw[i]);
      classified.data[i] = tbsf_pkg::stuff_byte(raw[i]);
    end
  end

  // holding register frees when the queue takes the word
  assign item_stall = frame_valid && frame_stall;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!item_stall) begin
      frame_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_data <= classified;
    end
  end

endmodule

FILE: sv/tbsf_queue.sv
// short fifo of classified frames between front and back
module tbsf_queue #(
  parameter int DEPTH = tbsf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  tbsf_pkg::frame_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tbsf_pkg::frame_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  tbsf_pkg::frame_t entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;
  logic             pop;

  assign push_stall = (count == CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count tracks pushes and pops
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/tbsf_back.sv
// back stage: walks one classified frame and emits its line bytes one per cycle while line_stall is low
module tbsf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  output logic                 frame_ready,
  input  tbsf_pkg::frame_t     frame_data,
  output logic                 line_valid,
  input  logic                 line_stall,
  output tbsf_pkg::line_word_t line_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ESC  = 4'b0010,
    ST_DATA = 4'b0100,
    ST_FOOT = 4'b1000
  } phase_t;

  phase_t               state;
  phase_t               state_next;
  logic [1:0]           idx;
  logic [1:0]           idx_next;
  tbsf_pkg::frame_t     cur;
  tbsf_pkg::line_word_t word_next;
  logic                 valid_next;
  logic                 advance;

  // output register moves when empty or taken
  assign advance     = !line_valid || !line_stall;
  assign frame_ready = advance && (state == ST_IDLE);

  // sequencer: header, then per byte an optional escape and the data, then footer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    word_next  = line_data;
    valid_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        word_next.line_byte = tbsf_pkg::FRAME_MARK;
        word_next.frame_end = 1'b0;
        valid_next          = frame_valid;
        idx_next            = '0;
        if (frame_valid) begin
          state_next = frame_data.esc[0] ? ST_ESC : ST_DATA;
        end
      end
      ST_ESC: begin
        word_next.line_byte = tbsf_pkg::ESCAPE_MARK;
        word_next.frame_end = 1'b0;
        valid_next          = 1'b1;
        state_next          = ST_DATA;
      end
      ST_DATA: begin
        word_next.line_byte = cur.data[idx];
        word_next.frame_end = 1'b0;
        valid_next          = 1'b1;
        if (idx == 2'(tbsf_pkg::PAYLOAD_BYTES - 1)) begin
          state_next = ST_FOOT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = cur.esc[idx + 1'b1] ? ST_ESC : ST_DATA;
        end
      end
      ST_FOOT: begin
        word_next.line_byte = tbsf_pkg::FRAME_MARK;
        word_next.frame_end = 1'b1;
        valid_next          = 1'b1;
        state_next          = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      line_valid <= 1'b0;
    end else if (advance) begin
      state      <= state_next;
      idx        <= idx_next;
      line_valid <= valid_next;
    end
  end

  // payload: current frame and output word
  always_ff @(posedge clk) begin
    if (frame_ready && frame_valid) begin
      cur <= frame_data;
    end
    if (advance) begin
      line_data <= word_next;
    end
  end

  // a frame in progress always has a byte on the line
  a_busy_shows: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> line_valid)
    else $error("frame in progress without a line byte");

  // an escape is always followed by the xored mark
  a_escape_pair: assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_stall && line_data.line_byte == tbsf_pkg::ESCAPE_MARK
    |=> line_valid && (line_data.line_byte == (tbsf_pkg::ESCAPE_MARK ^ tbsf_pkg::STUFF_XOR) ||
                       line_data.line_byte == (tbsf_pkg::FRAME_MARK ^ tbsf_pkg::STUFF_XOR)))
    else $error("escape not followed by a stuffed byte");

  // frame end only on a delimiter
  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    line_valid && line_data.frame_end |-> line_data.line_byte == tbsf_pkg::FRAME_MARK)
    else $error("frame end on a byte other than the delimiter");

endmodule

FILE: sv/telemetry_byte_stuffed_framer_core.sv
// top level of the byte-stuffed telemetry framer
// a taken word's header byte passes the front register, a queue entry and the back
// sequencer's output register, sending one line byte per cycle while line_stall is low;
// a frame is the header, each payload byte after an optional escape, and the footer
// the front takes a new word while the back still sends, up to the queue depth plus one
// reset (rst, synchronous) empties the front register, the queue and the output register
module telemetry_byte_stuffed_framer_core #(
  parameter int QUEUE_DEPTH = tbsf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  tbsf_pkg::item_word_t item_data,
  output logic                 line_valid,
  input  logic                 line_stall,
  output tbsf_pkg::line_word_t line_data
);

  logic             f_valid;
  logic             f_stall;
  tbsf_pkg::frame_t f_data;
  logic             q_valid;
  logic             q_ready;
  tbsf_pkg::frame_t q_data;

  // accept and classify
  tbsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item_data   (item_data),
    .frame_valid (f_valid),
    .frame_stall (f_stall),
    .frame_data  (f_data)
  );

  // decoupling queue
  tbsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // serialize frames onto the line
  tbsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (q_valid),
    .frame_ready (q_ready),
    .frame_data  (q_data),
    .line_valid  (line_valid),
    .line_stall  (line_stall),
    .line_data   (line_data)
  );

endmodule
